[sv/rational_fraction_reducer_unit_defines.svh]
// Assertion shorthands for the fraction reducer; sampled on clk, quiet in reset.
`ifndef RATIONAL_FRACTION_REDUCER_UNIT_DEFINES_SVH
`define RATIONAL_FRACTION_REDUCER_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define RFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfr same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define RFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfr next-cycle check failed");

`endif

[sv/rfr_pkg.sv]
package rfr_pkg;

  // Default width of every numerator and denominator.
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Handshake status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rfr_unit_sts_t;

endpackage

[sv/rfr_gcd.sv]
module rfr_gcd #(
  parameter int unsigned VALUE_WIDTH = rfr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [VALUE_WIDTH-1:0]    a_in,
  input  logic [VALUE_WIDTH-1:0]    b_in,
  output logic [VALUE_WIDTH-1:0]    gcd,
  output rfr_pkg::rfr_unit_sts_t    sts
);
  import rfr_pkg::*;

  localparam int unsigned SW = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {G_IDLE, G_STRIP, G_AODD, G_LOOP} gcd_state_t;

  gcd_state_t             state_r;
  logic [VALUE_WIDTH-1:0] a_r;
  logic [VALUE_WIDTH-1:0] b_r;
  logic [SW-1:0]          sh_r;
  logic [VALUE_WIDTH-1:0] g_r;
  logic                   done_r;

  // Shared compare and subtract: larger minus smaller
  logic                   a_gt_b;
  logic [VALUE_WIDTH-1:0] diff;

  assign a_gt_b = (a_r > b_r);
  assign diff   = a_gt_b ? (a_r - b_r) : (b_r - a_r);

  // Binary GCD: strip common twos, make a odd, then subtract and halve
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
      a_r     <= '0;
      b_r     <= '0;
      sh_r    <= '0;
      g_r     <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (start) begin
            a_r     <= a_in;
            b_r     <= b_in;
            sh_r    <= '0;
            state_r <= G_STRIP;
          end
        end
        G_STRIP: begin
          if (a_r[0] || b_r[0]) begin
            state_r <= G_AODD;
          end else begin
            a_r  <= a_r >> 1;
            b_r  <= b_r >> 1;
            sh_r <= sh_r + 1'b1;
          end
        end
        G_AODD: begin
          if (a_r[0]) begin
            state_r <= G_LOOP;
          end else begin
            a_r <= a_r >> 1;
          end
        end
        G_LOOP: begin
          if (b_r == '0) begin
            g_r     <= a_r << sh_r;
            done_r  <= 1'b1;
            state_r <= G_IDLE;
          end else if (!b_r[0]) begin
            b_r <= b_r >> 1;
          end else begin
            if (a_gt_b) begin
              a_r <= b_r;
            end
            b_r <= diff;
          end
        end
        default: begin
          state_r <= G_IDLE;
        end
      endcase
    end
  end

  assign gcd      = g_r;
  assign sts.busy = (state_r != G_IDLE);
  assign sts.done = done_r;

endmodule

[sv/rfr_div.sv]
module rfr_div #(
  parameter int unsigned VALUE_WIDTH = rfr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [VALUE_WIDTH-1:0]    dividend,
  input  logic [VALUE_WIDTH-1:0]    divisor,
  output logic [VALUE_WIDTH-1:0]    quotient,
  output rfr_pkg::rfr_unit_sts_t    sts
);
  import rfr_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  typedef enum logic {D_IDLE, D_RUN} div_state_t;

  div_state_t             state_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] q_r;
  logic [VALUE_WIDTH-1:0] dvs_r;
  logic [CW-1:0]          cnt_r;
  logic                   done_r;

  // Restoring step: bring down the next dividend bit and try the subtract
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   sub;
  logic                   fits;

  assign trial = {rem_r, q_r[VALUE_WIDTH-1]};
  assign sub   = trial - {1'b0, dvs_r};
  assign fits  = !sub[VALUE_WIDTH];

  // One quotient bit a cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      rem_r   <= '0;
      q_r     <= '0;
      dvs_r   <= '0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= '0;
            q_r     <= dividend;
            dvs_r   <= divisor;
            cnt_r   <= CW'(VALUE_WIDTH - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= fits ? sub[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
          q_r   <= {q_r[VALUE_WIDTH-2:0], fits};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign quotient = q_r;
  assign sts.busy = (state_r != D_IDLE);
  assign sts.done = done_r;

endmodule

[sv/rational_fraction_reducer_unit.sv]
// Fraction reducer: takes one signed numerator/denominator pair per beat and returns it in
// lowest terms with a positive denominator (0/1 for a zero numerator; a zero denominator
// passes the numerator through). Each pair runs through a binary GCD unit that removes
// one factor of two or does one compare-and-subtract per cycle, then through one
// restoring divider that is used twice, once for each magnitude. A pair with a zero operand
// skips both units. in_tready is high only while no pair is in flight; a finished result
// waits in the output register, and the next pair may be taken while it waits.
`include "rational_fraction_reducer_unit_defines.svh"

module rational_fraction_reducer_unit #(
  parameter int unsigned VALUE_WIDTH = rfr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [VW-1:0] numerator, [2VW-1:VW] denominator, rest padding
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [VW-1:0] reduced_numerator, [2VW-1:VW] reduced_denominator, rest zero
  output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]      out_tdata
);
  import rfr_pkg::*;

  localparam int unsigned W       = VALUE_WIDTH;
  localparam int unsigned TDATA_W = ((2*VALUE_WIDTH+7)/8)*8;

  typedef enum logic [2:0] {ST_IDLE, ST_GCD, ST_DIVN, ST_DIVD, ST_FIN} top_state_t;

  top_state_t    state_r;
  logic [W-1:0]  an_r;
  logic [W-1:0]  ad_r;
  logic [W-1:0]  g_r;
  logic          neg_r;
  logic [W-1:0]  res_n_r;
  logic [W-1:0]  res_d_r;
  logic          out_tvalid_r;
  logic [W-1:0]  out_n_r;
  logic [W-1:0]  out_d_r;

  logic [W-1:0]  in_n;
  logic [W-1:0]  in_d;
  logic [W-1:0]  mag_n;
  logic [W-1:0]  mag_d;
  logic          in_beat;
  logic          both_nz;
  logic          out_load;

  logic          gcd_start;
  logic [W-1:0]  gcd_g;
  rfr_unit_sts_t gcd_sts;

  logic          div_start;
  logic [W-1:0]  div_dvd;
  logic [W-1:0]  div_dvs;
  logic [W-1:0]  div_q;
  rfr_unit_sts_t div_sts;

  // Unpack the beat and take magnitudes
  assign in_n    = in_tdata[W-1:0];
  assign in_d    = in_tdata[2*W-1:W];
  assign mag_n   = in_n[W-1] ? (~in_n + 1'b1) : in_n;
  assign mag_d   = in_d[W-1] ? (~in_d + 1'b1) : in_d;
  assign in_tready = (state_r == ST_IDLE);
  assign in_beat = in_tvalid && in_tready;
  assign both_nz = (in_n != '0) && (in_d != '0);

  // Load the output register once it is free or being taken
  assign out_load = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);

  // Start the GCD on a general pair; reuse one divider for both magnitudes
  assign gcd_start = in_beat && both_nz;
  assign div_start = gcd_sts.done || ((state_r == ST_DIVN) && div_sts.done);
  assign div_dvd   = (state_r == ST_GCD) ? an_r  : ad_r;
  assign div_dvs   = (state_r == ST_GCD) ? gcd_g : g_r;

  rfr_gcd #(.VALUE_WIDTH(VALUE_WIDTH)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (mag_n),
    .b_in  (mag_d),
    .gcd   (gcd_g),
    .sts   (gcd_sts)
  );

  rfr_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // Sequence one pair and hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      an_r         <= '0;
      ad_r         <= '0;
      g_r          <= '0;
      neg_r        <= 1'b0;
      res_n_r      <= '0;
      res_d_r      <= '0;
      out_n_r      <= '0;
      out_d_r      <= '0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            an_r  <= mag_n;
            ad_r  <= mag_d;
            neg_r <= in_n[W-1] ^ in_d[W-1];
            if (in_n == '0) begin
              res_n_r <= '0;
              res_d_r <= W'(1);
              state_r <= ST_FIN;
            end else if (in_d == '0) begin
              res_n_r <= in_n;
              res_d_r <= '0;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          if (gcd_sts.done) begin
            g_r     <= gcd_g;
            state_r <= ST_DIVN;
          end
        end
        ST_DIVN: begin
          if (div_sts.done) begin
            res_n_r <= neg_r ? (~div_q + 1'b1) : div_q;
            state_r <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          if (div_sts.done) begin
            res_d_r <= div_q;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_n_r      <= res_n_r;
            out_d_r      <= res_d_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TDATA_W'({out_d_r, out_n_r});

  // Checks on the sequencer and its units
  `RFR_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)
  `RFR_ASSERT_IMPL(a_gcd_nonzero, gcd_sts.done, gcd_g != '0)
  `RFR_ASSERT_IMPL(a_units_idle, state_r == ST_IDLE, !gcd_sts.busy && !div_sts.busy)
  `RFR_ASSERT_IMPL(a_div_in_phase, div_sts.done, state_r == ST_DIVN || state_r == ST_DIVD)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned VW = rfr_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned DW = ((2 * VW + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  // Allow a margin for the drain
  localparam int unsigned DRAIN_CYCLES = 5 * VW + 64;
  localparam int unsigned RANDOM_PER_PHASE = 290;
  localparam int unsigned NUM_ROWS = 25;

  typedef logic [VW-1:0] value_t;

  localparam value_t MAX_POS  = {1'b0, {(VW-1){1'b1}}};
  localparam value_t MAX_NEG  = {1'b1, {(VW-2){1'b0}}, 1'b1};
  localparam value_t MOST_NEG = {1'b1, {(VW-1){1'b0}}};
  localparam value_t ONE      = value_t'(1);
  localparam value_t MINUS1   = {VW{1'b1}};

  typedef struct packed {
    value_t num;
    value_t den;
  } fraction_t;

  // typed: expectation is written in the row, otherwise the predictor supplies it
  typedef struct packed {
    value_t num;
    value_t den;
    bit     typed;
    value_t exp_num;
    value_t exp_den;
  } stim_row_t;

  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    // zero numerator always gives 0/1
    '{value_t'(0),  value_t'(0),  1'b1, value_t'(0), ONE},
    '{value_t'(0),  value_t'(5),  1'b1, value_t'(0), ONE},
    '{value_t'(0),  -value_t'(7), 1'b1, value_t'(0), ONE},
    '{value_t'(0),  MOST_NEG,     1'b1, value_t'(0), ONE},
    // zero denominator passes the numerator through
    '{value_t'(7),  value_t'(0),  1'b1, value_t'(7), value_t'(0)},
    '{-value_t'(7), value_t'(0),  1'b1, -value_t'(7), value_t'(0)},
    '{MAX_POS,      value_t'(0),  1'b1, MAX_POS,     value_t'(0)},
    '{MAX_NEG,      value_t'(0),  1'b1, MAX_NEG,     value_t'(0)},
    // extremes and sign placement
    '{MAX_POS,      MAX_POS,      1'b1, ONE,    ONE},
    '{MAX_POS,      MAX_NEG,      1'b1, MINUS1, ONE},
    '{MAX_NEG,      MAX_NEG,      1'b1, ONE,    ONE},
    '{ONE,          ONE,          1'b1, ONE,    ONE},
    '{ONE,          MINUS1,       1'b1, MINUS1, ONE},
    '{MINUS1,       MINUS1,       1'b1, ONE,    ONE},
    // most negative value: magnitude wraps back when it must be positive
    '{ONE,          MOST_NEG,     1'b1, MINUS1, MOST_NEG},
    '{MOST_NEG,     MOST_NEG,     1'b1, ONE,    ONE},
    '{MOST_NEG,     value_t'(2),  1'b0, '0, '0},
    '{value_t'(6),  value_t'(4),  1'b0, '0, '0},
    '{-value_t'(6), value_t'(4),  1'b0, '0, '0},
    '{value_t'(6),  -value_t'(4), 1'b0, '0, '0},
    '{ONE,          MAX_POS,      1'b0, '0, '0},
    '{MAX_NEG,      ONE,          1'b0, '0, '0},
    '{value_t'(32'h6000_0000), value_t'(32'h2000_0000), 1'b0, '0, '0},
    '{value_t'(32'h4000_0000), value_t'(32'h7FFF_FFFE), 1'b0, '0, '0},
    '{value_t'(32'h5555_5555), value_t'(32'hAAAA_AAAB), 1'b0, '0, '0}
  };

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;

  fraction_t pending_fractions [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pairs_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  rational_fraction_reducer_unit #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Reduce a fraction: divide both magnitudes by their GCD, sign onto the numerator
  function automatic fraction_t reduce_fraction(input value_t num, input value_t den);
    fraction_t res;
    value_t mag_n, mag_d, a, b, t, q_n, q_d;
    if (num == '0) begin
      res.num = '0;
      res.den = ONE;
      return res;
    end
    if (den == '0) begin
      res.num = num;
      res.den = '0;
      return res;
    end
    mag_n = num[VW-1] ? -num : num;
    mag_d = den[VW-1] ? -den : den;
    a = mag_n;
    b = mag_d;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    q_n = mag_n / a;
    q_d = mag_d / a;
    res.num = (num[VW-1] ^ den[VW-1]) ? -q_n : q_n;
    res.den = q_d;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Any value inside the field range, most negative value excluded
  function automatic value_t any_value();
    value_t v;
    v = $urandom;
    while (v == MOST_NEG) v = $urandom;
    return v;
  endfunction

  function automatic value_t with_sign(input value_t v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Draw one random pair, biased towards shared factors
  task automatic draw_pair(output value_t num, output value_t den);
    int unsigned shape;
    int unsigned sh_n, sh_d;
    value_t g;
    shape = $urandom_range(0, 99);
    if (shape < 30) begin
      num = any_value();
      den = any_value();
    end else if (shape < 60) begin
      // odd or even common factor up to 16 bits
      g = value_t'($urandom_range(1, 65535));
      num = with_sign(value_t'($urandom_range(1, 32767)) * g);
      den = with_sign(value_t'($urandom_range(1, 32767)) * g);
    end else if (shape < 75) begin
      // shared powers of two
      sh_n = $urandom_range(0, VW - 2);
      sh_d = $urandom_range(0, VW - 2);
      num = with_sign(value_t'($urandom_range(1, (1 << (VW - 1 - sh_n)) - 1)) << sh_n);
      den = with_sign(value_t'($urandom_range(1, (1 << (VW - 1 - sh_d)) - 1)) << sh_d);
    end else if (shape < 85) begin
      num = with_sign(value_t'($urandom_range(0, 20)));
      den = with_sign(value_t'($urandom_range(0, 20)));
    end else if (shape < 90) begin
      num = '0;
      den = any_value();
    end else if (shape < 95) begin
      num = any_value();
      den = '0;
    end else begin
      num = any_value();
      den = with_sign(num);
    end
  endtask

  // Offer one pair after a random gap and hold it until the beat is taken
  task automatic send_pair(input value_t num, input value_t den, input fraction_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DW'({den, num});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_fractions.push_back(want);
    pairs_sent++;
  endtask

  // Check each result beat against the oldest pending fraction, then re-roll the stall
  always @(posedge clk) begin : result_monitor
    fraction_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fractions.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", out_tdata));
      end else begin
        want = pending_fractions.pop_front();
        if (out_tdata[VW-1:0] !== want.num)
          report_mismatch($sformatf("reduced numerator %h, want %h (result %0d)",
                                    out_tdata[VW-1:0], want.num, results_checked));
        if (out_tdata[2*VW-1:VW] !== want.den)
          report_mismatch($sformatf("reduced denominator %h, want %h (result %0d)",
                                    out_tdata[2*VW-1:VW], want.den, results_checked));
        results_checked++;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_cnt, pending_fractions.size());
      $display("rational_fraction_reducer_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    value_t num, den;
    fraction_t want;
    int unsigned idle_mix [4];
    int unsigned stall_mix [4];
    idle_mix  = '{0, 75, 0, 21};
    stall_mix = '{0, 0, 75, 21};

    // Hold reset, then release it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      // Walk the directed table at full rate first
      if (p == 0) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (STIM_ROWS[r].typed) begin
            want.num = STIM_ROWS[r].exp_num;
            want.den = STIM_ROWS[r].exp_den;
          end else begin
            want = reduce_fraction(STIM_ROWS[r].num, STIM_ROWS[r].den);
          end
          send_pair(STIM_ROWS[r].num, STIM_ROWS[r].den, want);
        end
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        draw_pair(num, den);
        send_pair(num, den, reduce_fraction(num, den));
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then watch for stray beats
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_fractions.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_fractions.size()));

    $display("Reduced %0d fraction pairs (%0d from the directed table) across four",
             pairs_sent, NUM_ROWS);
    $display("flow-control mixes; %0d results compared, %0d mismatches.",
             results_checked, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("rational_fraction_reducer_unit verification clean");
    end else begin
      $display("rational_fraction_reducer_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/rfr_pkg.sv
sv/rfr_gcd.sv
sv/rfr_div.sv
sv/rational_fraction_reducer_unit.sv
tb/tb_top.sv
